>>> hdl/delta_list_timer_queue_assert.svh
// Assertion macros for the delta-list timer queue.
`ifndef DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define DLTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dltq check failed");
`define DLTQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dltq check failed");
`else
`define DLTQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DLTQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/dltq_pkg.sv
// Shared types and constants of the delta-list timer queue.
package dltq_pkg;
    localparam int DLTQ_NUM_TIMERS = 32;
    localparam int DELTA_W = 31;
    localparam int ID_W = 32;
    localparam int FUNC_W = 2;
    localparam int KIND_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_DEL  = 2'd1,
        FUNC_TICK = 2'd2
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 2'd0,
        KIND_DEL = 2'd1,
        KIND_EXP = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_A_POP,
        S_A_NEXT,
        S_INS_RD,
        S_INS_CMP,
        S_INS_LINK,
        S_INS_LINK2,
        S_D_RD,
        S_D_CMP,
        S_D_FIX,
        S_D_SUM,
        S_FA_1,
        S_FA_2,
        S_T_RD,
        S_T_SUB,
        S_T_CHK,
        S_T_EXP
    } t_state;

    typedef struct packed {
        logic               ge;
        logic [DELTA_W-1:0] diff;
        logic [DELTA_W-1:0] sum_sat;
    } t_alu_res;
endpackage

>>> hdl/dltq_alu.sv
// Shared delta unit: compare, subtract and saturating add.
module dltq_alu (
    input  logic [dltq_pkg::DELTA_W-1:0] i_a,
    input  logic [dltq_pkg::DELTA_W-1:0] i_b,
    output dltq_pkg::t_alu_res           o_res
);
    import dltq_pkg::*;

    logic [DELTA_W:0] sum;

    assign sum = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        o_res.ge      = (i_a >= i_b);
        o_res.diff    = i_a - i_b;
        // clamp at the largest delta
        o_res.sum_sat = sum[DELTA_W] ? {DELTA_W{1'b1}} : sum[DELTA_W-1:0];
    end
endmodule

>>> hdl/delta_list_timer_queue.sv
// Top level of the delta-list timer queue: sequencer, entry memories, delta unit.
//
//  channel  | handshake         | fields
//  ---------+-------------------+------------------------------------------------
//  command  | start, busy       | i_func i_periodic i_delay i_period i_target_id
//           |                   | i_tick_count
//  result   | o_valid (strobe)  | o_kind o_timer_id o_status o_last
//
// After reset a clearing pass chains the free list in index order, with busy high.
// An add takes a free entry, walks past the entries that expire no later and links
// the new entry in; it fails without a walk when the pool is empty.
// A delete compares ids down the list and unlinks and frees a match; a miss changes nothing.
// A tick ends with no result on an empty list, else lowers the head delta and checks the head;
// each expiry is followed by a free-list append or a re-insert walk.
// The walk is bound by the single read port of the entry memories: one entry at a time.
// Results are one-cycle strobes; the receiver cannot stall them.
`include "delta_list_timer_queue_assert.svh"
module delta_list_timer_queue #(
    parameter int NUM_TIMERS = dltq_pkg::DLTQ_NUM_TIMERS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dltq_pkg::FUNC_W-1:0]   i_func,
    input  logic                          i_periodic,
    input  logic [dltq_pkg::DELTA_W-1:0]  i_delay,
    input  logic [dltq_pkg::DELTA_W-1:0]  i_period,
    input  logic [dltq_pkg::ID_W-1:0]     i_target_id,
    input  logic [dltq_pkg::DELTA_W-1:0]  i_tick_count,
    output logic                          o_valid,
    output logic [dltq_pkg::KIND_W-1:0]   o_kind,
    output logic [dltq_pkg::ID_W-1:0]     o_timer_id,
    output logic                          o_status,
    output logic                          o_last
);
    import dltq_pkg::*;

    localparam int AW = $clog2(NUM_TIMERS);
    localparam int PW = $clog2(NUM_TIMERS + 1);
    localparam logic [PW-1:0] NIL = PW'(NUM_TIMERS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);

    // entry memories
    logic [PW-1:0]      r_next_mem   [NUM_TIMERS];
    logic [DELTA_W-1:0] r_delta_mem  [NUM_TIMERS];
    logic [ID_W-1:0]    r_id_mem     [NUM_TIMERS];
    logic [DELTA_W-1:0] r_period_mem [NUM_TIMERS];
    logic               r_pflag_mem  [NUM_TIMERS];

    logic [PW-1:0]      r_nx_rd;
    logic [DELTA_W-1:0] r_dl_rd;
    logic [ID_W-1:0]    r_id_rd;
    logic [DELTA_W-1:0] r_pd_rd;
    logic               r_pc_rd;

    // memory ports driven by the sequencer
    logic [AW-1:0]      n_raddr;
    logic               nx_we, dl_we, id_we, pd_we, pc_we;
    logic [AW-1:0]      nx_wa, dl_wa, ent_wa;
    logic [PW-1:0]      nx_wd;
    logic [DELTA_W-1:0] dl_wd, pd_wd;
    logic [ID_W-1:0]    id_wd;
    logic               pc_wd;

    // sequencer state
    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [PW-1:0]      r_act_head, n_act_head;
    logic [PW-1:0]      r_free_head, n_free_head;
    logic [PW-1:0]      r_free_tail, n_free_tail;
    logic [ID_W-1:0]    r_next_id, n_next_id;
    t_func              r_func, n_func;
    logic               r_periodic, n_periodic;
    logic [DELTA_W-1:0] r_d, n_d;
    logic [DELTA_W-1:0] r_period, n_period;
    logic [ID_W-1:0]    r_target, n_target;
    logic [DELTA_W-1:0] r_tick, n_tick;
    logic [PW-1:0]      r_node, n_node;
    logic [PW-1:0]      r_cur, n_cur;
    logic [PW-1:0]      r_prev, n_prev;
    logic [PW-1:0]      r_nxt, n_nxt;
    logic [DELTA_W-1:0] r_cur_delta, n_cur_delta;
    logic [PW-1:0]      r_cnt, n_cnt;
    logic               r_pend, n_pend;
    logic [ID_W-1:0]    r_pend_id, n_pend_id;

    // result register
    logic               r_o_valid, n_o_valid;
    t_kind              r_o_kind, n_o_kind;
    logic [ID_W-1:0]    r_o_id, n_o_id;
    logic               r_o_status, n_o_status;
    logic               r_o_last, n_o_last;

    logic [DELTA_W-1:0] alu_a, alu_b;
    t_alu_res           alu_res;

    dltq_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // steer the shared unit by step
    always_comb begin
        case (r_state)
            S_INS_CMP:   begin alu_a = r_d;         alu_b = r_dl_rd;     end
            S_INS_LINK2: begin alu_a = r_cur_delta; alu_b = r_d;         end
            S_D_SUM:     begin alu_a = r_dl_rd;     alu_b = r_cur_delta; end
            S_T_SUB:     begin alu_a = r_dl_rd;     alu_b = r_tick;      end
            default:     begin alu_a = r_d;         alu_b = r_dl_rd;     end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) r_next_mem[nx_wa] <= nx_wd;
        if (dl_we) r_delta_mem[dl_wa] <= dl_wd;
        if (id_we) r_id_mem[ent_wa] <= id_wd;
        if (pd_we) r_period_mem[ent_wa] <= pd_wd;
        if (pc_we) r_pflag_mem[ent_wa] <= pc_wd;
        r_nx_rd <= r_next_mem[n_raddr];
        r_dl_rd <= r_delta_mem[n_raddr];
        r_id_rd <= r_id_mem[n_raddr];
        r_pd_rd <= r_period_mem[n_raddr];
        r_pc_rd <= r_pflag_mem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_act_head  <= NIL;
            r_free_head <= '0;
            r_free_tail <= PW'(NUM_TIMERS - 1);
            r_next_id   <= '0;
            r_pend      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_act_head  <= n_act_head;
            r_free_head <= n_free_head;
            r_free_tail <= n_free_tail;
            r_next_id   <= n_next_id;
            r_pend      <= n_pend;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_periodic  <= n_periodic;
        r_d         <= n_d;
        r_period    <= n_period;
        r_target    <= n_target;
        r_tick      <= n_tick;
        r_node      <= n_node;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_nxt       <= n_nxt;
        r_cur_delta <= n_cur_delta;
        r_cnt       <= n_cnt;
        r_pend_id   <= n_pend_id;
        r_o_kind    <= n_o_kind;
        r_o_id      <= n_o_id;
        r_o_status  <= n_o_status;
        r_o_last    <= n_o_last;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_act_head  = r_act_head;
        n_free_head = r_free_head;
        n_free_tail = r_free_tail;
        n_next_id   = r_next_id;
        n_func      = r_func;
        n_periodic  = r_periodic;
        n_d         = r_d;
        n_period    = r_period;
        n_target    = r_target;
        n_tick      = r_tick;
        n_node      = r_node;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_nxt       = r_nxt;
        n_cur_delta = r_cur_delta;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_id   = r_pend_id;
        n_o_valid   = 1'b0;
        n_o_kind    = r_o_kind;
        n_o_id      = r_o_id;
        n_o_status  = r_o_status;
        n_o_last    = r_o_last;
        n_raddr     = r_cur[AW-1:0];
        nx_we       = 1'b0;
        nx_wa       = r_node[AW-1:0];
        nx_wd       = NIL;
        dl_we       = 1'b0;
        dl_wa       = r_node[AW-1:0];
        dl_wd       = r_d;
        id_we       = 1'b0;
        pd_we       = 1'b0;
        pc_we       = 1'b0;
        ent_wa      = r_free_head[AW-1:0];
        id_wd       = r_next_id + ID_W'(1);
        pd_wd       = (r_period == '0) ? DELTA_W'(1) : r_period;
        pc_wd       = r_periodic;

        unique case (r_state)
            S_CLR: begin
                // chain the free list in index order
                nx_we = 1'b1;
                nx_wa = r_clr;
                nx_wd = (r_clr == LAST_IDX) ? NIL : PW'(r_clr) + PW'(1);
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST_IDX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_periodic = i_periodic;
                    n_d        = i_delay;
                    n_period   = i_period;
                    n_target   = i_target_id;
                    n_tick     = i_tick_count;
                    n_cur      = r_act_head;
                    n_prev     = NIL;
                    case (i_func)
                        FUNC_ADD: begin
                            n_func  = FUNC_ADD;
                            n_state = S_A_POP;
                        end
                        FUNC_DEL: begin
                            n_func  = FUNC_DEL;
                            n_state = S_D_RD;
                        end
                        FUNC_TICK: begin
                            n_func  = FUNC_TICK;
                            n_state = S_T_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_A_POP: begin
                if (r_free_head == NIL) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_ADD;
                    n_o_id     = '0;
                    n_o_status = 1'b1;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    // take the free head, stamp id and reload
                    n_node    = r_free_head;
                    n_raddr   = r_free_head[AW-1:0];
                    n_next_id = r_next_id + ID_W'(1);
                    id_we     = 1'b1;
                    pd_we     = 1'b1;
                    pc_we     = 1'b1;
                    n_state   = S_A_NEXT;
                end
            end
            S_A_NEXT: begin
                n_free_head = r_nx_rd;
                if (r_nx_rd == NIL) n_free_tail = NIL;
                n_cur   = r_act_head;
                n_prev  = NIL;
                n_state = S_INS_RD;
            end
            S_INS_RD: begin
                n_raddr = r_cur[AW-1:0];
                n_state = (r_cur == NIL) ? S_INS_LINK : S_INS_CMP;
            end
            S_INS_CMP: begin
                if (alu_res.ge) begin
                    // walk past entries that expire no later
                    n_d     = alu_res.diff;
                    n_prev  = r_cur;
                    n_cur   = r_nx_rd;
                    n_state = S_INS_RD;
                end else begin
                    n_cur_delta = r_dl_rd;
                    n_state     = S_INS_LINK;
                end
            end
            S_INS_LINK: begin
                dl_we   = 1'b1;
                dl_wa   = r_node[AW-1:0];
                dl_wd   = r_d;
                nx_we   = 1'b1;
                nx_wa   = r_node[AW-1:0];
                nx_wd   = r_cur;
                n_state = S_INS_LINK2;
            end
            S_INS_LINK2: begin
                if (r_prev == NIL) begin
                    n_act_head = r_node;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = r_prev[AW-1:0];
                    nx_wd = r_node;
                end
                if (r_cur != NIL) begin
                    dl_we = 1'b1;
                    dl_wa = r_cur[AW-1:0];
                    dl_wd = alu_res.diff;
                end
                if (r_func == FUNC_ADD) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_ADD;
                    n_o_id     = r_next_id;
                    n_o_status = 1'b0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_T_CHK;
                end
            end
            S_D_RD: begin
                n_raddr = r_cur[AW-1:0];
                if (r_cur == NIL) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_DEL;
                    n_o_id     = '0;
                    n_o_status = 1'b0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_D_CMP;
                end
            end
            S_D_CMP: begin
                if (r_id_rd == r_target) begin
                    n_nxt       = r_nx_rd;
                    n_cur_delta = r_dl_rd;
                    n_node      = r_cur;
                    n_state     = S_D_FIX;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = r_nx_rd;
                    n_state = S_D_RD;
                end
            end
            S_D_FIX: begin
                n_raddr = r_nxt[AW-1:0];
                n_state = S_D_SUM;
            end
            S_D_SUM: begin
                // fold the removed delta into the successor, then unlink
                if (r_nxt != NIL) begin
                    dl_we = 1'b1;
                    dl_wa = r_nxt[AW-1:0];
                    dl_wd = alu_res.sum_sat;
                end
                if (r_prev == NIL) begin
                    n_act_head = r_nxt;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = r_prev[AW-1:0];
                    nx_wd = r_nxt;
                end
                n_state = S_FA_1;
            end
            S_FA_1: begin
                nx_we   = 1'b1;
                nx_wa   = r_node[AW-1:0];
                nx_wd   = NIL;
                n_state = S_FA_2;
            end
            S_FA_2: begin
                if (r_free_tail == NIL) begin
                    n_free_head = r_node;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = r_free_tail[AW-1:0];
                    nx_wd = r_node;
                end
                n_free_tail = r_node;
                if (r_func == FUNC_DEL) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_DEL;
                    n_o_id     = '0;
                    n_o_status = 1'b0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_T_CHK;
                end
            end
            S_T_RD: begin
                n_raddr = r_act_head[AW-1:0];
                n_state = (r_act_head == NIL) ? S_IDLE : S_T_SUB;
            end
            S_T_SUB: begin
                // lower the head delta, stop at zero
                dl_we   = 1'b1;
                dl_wa   = r_act_head[AW-1:0];
                dl_wd   = alu_res.ge ? alu_res.diff : '0;
                n_cnt   = '0;
                n_pend  = 1'b0;
                n_state = S_T_CHK;
            end
            S_T_CHK: begin
                n_raddr = r_act_head[AW-1:0];
                if (r_act_head == NIL || r_cnt == NIL) begin
                    n_o_valid  = r_pend;
                    n_o_kind   = KIND_EXP;
                    n_o_id     = r_pend_id;
                    n_o_status = 1'b0;
                    n_o_last   = 1'b1;
                    n_pend     = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_T_EXP;
                end
            end
            S_T_EXP: begin
                if (r_dl_rd != '0) begin
                    n_o_valid  = r_pend;
                    n_o_kind   = KIND_EXP;
                    n_o_id     = r_pend_id;
                    n_o_status = 1'b0;
                    n_o_last   = 1'b1;
                    n_pend     = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    // hold this expiry until we know whether another follows
                    n_o_valid  = r_pend;
                    n_o_kind   = KIND_EXP;
                    n_o_id     = r_pend_id;
                    n_o_status = 1'b0;
                    n_o_last   = 1'b0;
                    n_pend     = 1'b1;
                    n_pend_id  = r_id_rd;
                    n_cnt      = r_cnt + PW'(1);
                    n_node     = r_act_head;
                    n_act_head = r_nx_rd;
                    if (r_pc_rd) begin
                        n_d     = r_pd_rd;
                        n_cur   = r_nx_rd;
                        n_prev  = NIL;
                        n_state = S_INS_RD;
                    end else begin
                        n_state = S_FA_1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_kind     = r_o_kind;
    assign o_timer_id = r_o_id;
    assign o_status   = r_o_status;
    assign o_last     = r_o_last;

    `DLTQ_ASSERT_IMP(a_add_last, i_clk, i_rst_n, r_o_valid && r_o_kind == KIND_ADD, r_o_last)
    `DLTQ_ASSERT_IMP(a_fail_shape, i_clk, i_rst_n, r_o_valid && r_o_status,
        r_o_kind == KIND_ADD && r_o_id == '0)
    `DLTQ_ASSERT_IMP(a_free_ends, i_clk, i_rst_n, r_state == S_IDLE,
        (r_free_head == NIL) == (r_free_tail == NIL))
    `DLTQ_ASSERT_NXT(a_add_busy, i_clk, i_rst_n, start && !busy && i_func == FUNC_ADD, busy)
endmodule

>>> verif/tb_delta_list_timer_queue.sv
// Self-checking testbench for the delta-list timer queue: directed and random items.
module tb_delta_list_timer_queue;
    import dltq_pkg::*;

    localparam int NT = DLTQ_NUM_TIMERS;
    localparam logic [5:0] NIL = 6'(NT);
    localparam logic [30:0] DMAX = 31'h7FFF_FFFF;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        t_kind       kind;
        logic [31:0] id;
        logic        status;
        logic        last;
    } t_timer_event;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_func;
    logic              i_periodic;
    logic [30:0]       i_delay;
    logic [30:0]       i_period;
    logic [31:0]       i_target_id;
    logic [30:0]       i_tick_count;
    logic              o_valid;
    logic [1:0]        o_kind;
    logic [31:0]       o_timer_id;
    logic              o_status;
    logic              o_last;

    // Expected events, oldest first.
    t_timer_event pending_events[$];
    int           errors;
    bit           quiet_phase;

    // Shadow copy of the timer pool.
    logic [31:0] sh_next_id;
    logic [30:0] sh_delta  [NT];
    logic [31:0] sh_id     [NT];
    logic [30:0] sh_period [NT];
    logic        sh_per    [NT];
    logic [5:0]  sh_nxt    [NT];
    logic [5:0]  sh_prv    [NT];
    logic [5:0]  act_head, act_tail, free_head, free_tail;

    delta_list_timer_queue dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_periodic   (i_periodic),
        .i_delay      (i_delay),
        .i_period     (i_period),
        .i_target_id  (i_target_id),
        .i_tick_count (i_tick_count),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_timer_id   (o_timer_id),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- shadow pool
    task automatic pool_reset();
        sh_next_id = '0;
        for (int i = 0; i < NT; i++) begin
            sh_delta[i]  = '0;
            sh_id[i]     = '0;
            sh_period[i] = '0;
            sh_per[i]    = 1'b0;
            sh_nxt[i]    = (i + 1 < NT) ? 6'(i + 1) : NIL;
            sh_prv[i]    = (i > 0) ? 6'(i - 1) : NIL;
        end
        act_head  = NIL;
        act_tail  = NIL;
        free_head = '0;
        free_tail = 6'(NT - 1);
    endtask

    task automatic free_push(input logic [5:0] i);
        sh_nxt[i] = NIL;
        sh_prv[i] = free_tail;
        if (free_tail != NIL) sh_nxt[free_tail] = i;
        else free_head = i;
        free_tail = i;
    endtask

    task automatic active_drop(input logic [5:0] i);
        logic [5:0] p, n;
        p = sh_prv[i];
        n = sh_nxt[i];
        if (p != NIL) sh_nxt[p] = n;
        else act_head = n;
        if (n != NIL) sh_prv[n] = p;
        else act_tail = p;
        sh_nxt[i] = NIL;
        sh_prv[i] = NIL;
    endtask

    // Walk past every entry with an equal or earlier expiry, then splice in.
    task automatic active_place(input logic [5:0] i, input logic [30:0] d);
        logic [5:0] cur, p;
        int         steps;
        cur   = act_head;
        steps = 0;
        while (cur != NIL && steps < NT && d >= sh_delta[cur]) begin
            d     = d - sh_delta[cur];
            cur   = sh_nxt[cur];
            steps++;
        end
        sh_delta[i] = d;
        if (cur == NIL) begin
            sh_prv[i] = act_tail;
            sh_nxt[i] = NIL;
            if (act_tail != NIL) sh_nxt[act_tail] = i;
            else act_head = i;
            act_tail = i;
        end else begin
            p = sh_prv[cur];
            sh_prv[i] = p;
            sh_nxt[i] = cur;
            if (p != NIL) sh_nxt[p] = i;
            else act_head = i;
            sh_prv[cur]   = i;
            sh_delta[cur] = sh_delta[cur] - d;
        end
    endtask

    task automatic expect_event(input t_kind k, input logic [31:0] id, input logic st,
                                input logic lst);
        t_timer_event ev;
        ev.kind   = k;
        ev.id     = id;
        ev.status = st;
        ev.last   = lst;
        pending_events.push_back(ev);
    endtask

    // Apply one accepted command to the shadow pool and queue what it should emit.
    task automatic apply_command(input logic [1:0] fn, input logic per, input logic [30:0] dly,
                                 input logic [30:0] prd, input logic [31:0] tgt,
                                 input logic [30:0] tcnt);
        logic [5:0] i, cur, n;
        logic [31:0] s;
        int count;
        case (fn)
            FUNC_ADD: begin
                i = free_head;
                if (i == NIL) begin
                    expect_event(KIND_ADD, '0, 1'b1, 1'b1);
                end else begin
                    n = sh_nxt[i];
                    if (n != NIL) begin
                        free_head = n;
                        sh_prv[n] = NIL;
                    end else begin
                        free_head = NIL;
                        free_tail = NIL;
                    end
                    sh_nxt[i]    = NIL;
                    sh_prv[i]    = NIL;
                    sh_next_id   = sh_next_id + 32'd1;
                    sh_id[i]     = sh_next_id;
                    sh_per[i]    = per;
                    sh_period[i] = (prd == '0) ? 31'd1 : prd;
                    active_place(i, dly);
                    expect_event(KIND_ADD, sh_next_id, 1'b0, 1'b1);
                end
            end
            FUNC_DEL: begin
                cur = act_head;
                for (int k = 0; k < NT && cur != NIL; k++) begin
                    if (sh_id[cur] == tgt) begin
                        n = sh_nxt[cur];
                        if (n != NIL) begin
                            s = 32'(sh_delta[n]) + 32'(sh_delta[cur]);
                            sh_delta[n] = (s > 32'(DMAX)) ? DMAX : s[30:0];
                        end
                        active_drop(cur);
                        free_push(cur);
                        break;
                    end
                    cur = sh_nxt[cur];
                end
                expect_event(KIND_DEL, '0, 1'b0, 1'b1);
            end
            FUNC_TICK: begin
                count = 0;
                if (act_head != NIL) begin
                    cur = act_head;
                    sh_delta[cur] = (sh_delta[cur] > tcnt) ? sh_delta[cur] - tcnt : '0;
                    while (act_head != NIL && sh_delta[act_head] == '0 && count < NT) begin
                        cur = act_head;
                        active_drop(cur);
                        expect_event(KIND_EXP, sh_id[cur], 1'b0, 1'b0);
                        count++;
                        if (sh_per[cur]) active_place(cur, sh_period[cur]);
                        else free_push(cur);
                    end
                    // Flag the final expiry of this tick.
                    if (count > 0) pending_events[$].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    function automatic int active_count();
        logic [5:0] cur;
        int c;
        c   = 0;
        cur = act_head;
        while (cur != NIL && c < NT) begin
            c++;
            cur = sh_nxt[cur];
        end
        return c;
    endfunction

    // Pick the id of a random live timer; fall back to a random id if none are live.
    function automatic logic [31:0] live_timer_id();
        logic [5:0] cur;
        int c, pick;
        c = active_count();
        if (c == 0) return $urandom;
        pick = $urandom_range(c - 1);
        cur  = act_head;
        for (int k = 0; k < pick; k++) cur = sh_nxt[cur];
        return sh_id[cur];
    endfunction

    // ---------------------------------------------------------------- driving
    // Hold the item on the ports until the block takes it; start stays high on return.
    task automatic send_item(input logic [1:0] fn, input logic per, input logic [30:0] dly,
                             input logic [30:0] prd, input logic [31:0] tgt,
                             input logic [30:0] tcnt);
        start        <= 1'b1;
        i_func       <= fn;
        i_periodic   <= per;
        i_delay      <= dly;
        i_period     <= prd;
        i_target_id  <= tgt;
        i_tick_count <= tcnt;
        do @(posedge i_clk); while (busy);
        apply_command(fn, per, dly, prd, tgt, tcnt);
    endtask

    // Idle between items: mostly back to back, sometimes short, rarely long.
    task automatic idle_gap();
        int r, n;
        r = $urandom_range(99);
        if (quiet_phase || r < 60) n = 0;
        else if (r < 93) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic add_timer(input logic per, input logic [30:0] dly, input logic [30:0] prd);
        send_item(FUNC_ADD, per, dly, prd, $urandom, 31'($urandom));
        idle_gap();
    endtask

    task automatic delete_timer(input logic [31:0] tgt);
        send_item(FUNC_DEL, 1'($urandom), 31'($urandom), 31'($urandom), tgt, 31'($urandom));
        idle_gap();
    endtask

    task automatic tick(input logic [30:0] tcnt);
        send_item(FUNC_TICK, 1'($urandom), 31'($urandom), 31'($urandom), $urandom, tcnt);
        idle_gap();
    endtask

    // ---------------------------------------------------------------- result check
    always @(posedge i_clk) begin
        t_timer_event ev;
        if (i_rst_n && o_valid) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result kind=%0d id=%0h status=%0b last=%0b",
                         $time, o_kind, o_timer_id, o_status, o_last);
                errors++;
            end else begin
                ev = pending_events.pop_front();
                if (o_kind !== ev.kind || o_timer_id !== ev.id ||
                    o_status !== ev.status || o_last !== ev.last) begin
                    $display("%0t: mismatch expected kind=%0d id=%0h status=%0b last=%0b",
                             $time, ev.kind, ev.id, ev.status, ev.last);
                    $display("%0t:          actual   kind=%0d id=%0h status=%0b last=%0b",
                             $time, o_kind, o_timer_id, o_status, o_last);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests
    // Zero delay expires on a zero tick; the largest delay survives a large tick.
    task automatic test_add_and_expire();
        add_timer(1'b0, 31'd0, 31'd0);
        tick(31'd0);
        add_timer(1'b0, DMAX, DMAX);
        tick(DMAX - 31'd1);
        tick(31'd0);
        tick(31'd1);
        tick(31'd5);                      // empty list: nothing comes back
    endtask

    // Equal expiries stay in add order and expire together from one tick.
    task automatic test_ordering();
        add_timer(1'b0, 31'd5, 31'd0);
        add_timer(1'b0, 31'd3, 31'd0);
        add_timer(1'b0, 31'd5, 31'd0);
        add_timer(1'b0, 31'd9, 31'd0);
        tick(31'd3);
        tick(31'd2);
        tick(DMAX);
    endtask

    // Delete the head, the tail, a middle entry and an id that is not live.
    task automatic test_delete();
        logic [31:0] first_id;
        first_id = sh_next_id + 32'd1;
        add_timer(1'b0, 31'd4, 31'd0);
        add_timer(1'b0, 31'd8, 31'd0);
        add_timer(1'b0, 31'd12, 31'd0);
        add_timer(1'b0, 31'd16, 31'd0);
        delete_timer(first_id);
        delete_timer(first_id + 32'd3);
        delete_timer(first_id + 32'd1);
        delete_timer(32'hFFFF_FFFF);
        delete_timer(first_id);
        tick(31'd12);
    endtask

    // A zero period reloads as one; periodic timers keep coming back until deleted.
    task automatic test_periodic();
        logic [31:0] first_id;
        first_id = sh_next_id + 32'd1;
        add_timer(1'b1, 31'd0, 31'd0);
        add_timer(1'b1, 31'd2, 31'd3);
        tick(31'd0);
        tick(31'd1);
        tick(31'd1);
        tick(31'd4);
        delete_timer(first_id);
        delete_timer(first_id + 32'd1);
    endtask

    // The unused operation code is taken but answers nothing.
    task automatic test_unused_func();
        send_item(FUNC_UNUSED, 1'b1, DMAX, DMAX, '1, DMAX);
        idle_gap();
        tick(31'd0);
    endtask

    // Fill the pool, overflow it, then drain it again by deletes and one big tick.
    task automatic test_pool_full();
        int n;
        n = NT - active_count();
        for (int k = 0; k < n; k++) add_timer(k[0], 31'($urandom_range(0, 6)), 31'd2);
        add_timer(1'b0, 31'd1, 31'd1);
        add_timer(1'b1, 31'd1, 31'd1);
        tick(31'd0);
        tick(31'd3);
        while (act_head != NIL) delete_timer(sh_id[act_head]);
        tick(DMAX);
    endtask

    // Mostly small delays and ticks so timers live and die often; a few full-width values.
    task automatic test_random(input int n_items);
        int r;
        logic [30:0] dly, prd, tcnt;
        for (int k = 0; k < n_items; k++) begin
            if (k % 60 == 0) quiet_phase = ($urandom_range(3) == 0);
            r    = $urandom_range(99);
            dly  = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40));
            prd  = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 25));
            tcnt = ($urandom_range(19) == 0) ? 31'($urandom) : 31'($urandom_range(0, 12));
            if (r < 40) add_timer(1'($urandom), dly, prd);
            else if (r < 62) delete_timer(($urandom_range(4) == 0) ? $urandom : live_timer_id());
            else if (r < 96) tick(tcnt);
            else begin
                send_item(FUNC_UNUSED, 1'($urandom), 31'($urandom), 31'($urandom), $urandom,
                          31'($urandom));
                idle_gap();
            end
        end
        quiet_phase = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        int waited;
        errors      = 0;
        quiet_phase = 1'b0;
        pool_reset();
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_func       <= FUNC_ADD;
        i_periodic   <= 1'b0;
        i_delay      <= '0;
        i_period     <= '0;
        i_target_id  <= '0;
        i_tick_count <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_add_and_expire();
        test_ordering();
        test_delete();
        test_periodic();
        test_unused_func();
        test_pool_full();
        test_random(285);

        start  <= 1'b0;
        waited = 0;
        while (pending_events.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);

        if (errors == 0 && pending_events.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Bound the run well beyond the slowest legal schedule.
    initial begin
        #400_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
